/* hw/rtl/hhfs_pkg.sv */
`default_nettype none
package hhfs_pkg;

   localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
   localparam logic [63:0] HALF_Q31 = 64'h0000_0000_4000_0000;
   localparam logic [37:0] SUM_CAP  = 38'h20_0000_0000;
   localparam int unsigned QUO_BITS = 33;

   // Work item after classification: saturated recombination and chosen emission.
   typedef struct packed {
      logic        first_site;
      logic [31:0] recomb;
      logic [31:0] emit;
   } item_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_ADD,
      S_EMUL,
      S_ACC,
      S_NREAD,
      S_NLOAD,
      S_DIV,
      S_OUT
   } back_state_type;

endpackage
`default_nettype wire

/* hw/rtl/hhfs_req_if.sv */
`default_nettype none
interface hhfs_req_if;
   logic        valid;
   logic        ready;
   logic        first_site;
   logic        ref_allele;
   logic        query_allele;
   logic        query_missing;
   logic [31:0] recomb_prob;
   logic [31:0] emit_mismatch;
   logic [31:0] emit_match;

   modport source (output valid, first_site, ref_allele, query_allele, query_missing,
                   recomb_prob, emit_mismatch, emit_match, input ready);
   modport sink (input valid, first_site, ref_allele, query_allele, query_missing,
                 recomb_prob, emit_mismatch, emit_match, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hhfs_rsp_if.sv */
`default_nettype none
interface hhfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  hap_index;
   logic [31:0] forward_prob;
   logic [37:0] scale_sum;
   logic        site_done;

   modport source (output valid, hap_index, forward_prob, scale_sum, site_done, input ready);
   modport sink (input valid, hap_index, forward_prob, scale_sum, site_done, output ready);
endinterface
`default_nettype wire

/* hw/rtl/hhfs_front.sv */
`default_nettype none
module hhfs_front import hhfs_pkg::*; (
   hhfs_req_if.sink  req,
   input  wire logic q_full,
   output logic      q_push,
   output item_type  q_item
);

   logic        match;
   logic [31:0] emit_sel;

   assign req.ready = !q_full;
   assign q_push    = req.valid && req.ready;

   // A missing query allele counts as a match.
   assign match    = req.query_missing || (req.ref_allele == req.query_allele);
   assign emit_sel = match ? req.emit_match : req.emit_mismatch;

   assign q_item.first_site = req.first_site;
   assign q_item.recomb     = (req.recomb_prob > ONE_Q31) ? ONE_Q31 : req.recomb_prob;
   assign q_item.emit       = (emit_sel > ONE_Q31) ? ONE_Q31 : emit_sel;

endmodule
`default_nettype wire

/* hw/rtl/hhfs_queue.sv */
`default_nettype none
module hhfs_queue import hhfs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          valid,
   output item_type      item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/hhfs_back.sv */
`default_nettype none
module hhfs_back import hhfs_pkg::*; #(
   parameter int MAX_HAPS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] hap_count,
   input  wire logic       q_valid,
   input  wire item_type   q_item,
   output logic            q_pop,
   hhfs_rsp_if.source      rsp
);

   localparam int IW = $clog2(MAX_HAPS);
   localparam int CW = $clog2(MAX_HAPS + 1);

   // Uniform prior for every possible haplotype count, built at elaboration.
   logic [31:0] u_tab [MAX_HAPS + 1];
   for (genvar g = 0; g <= MAX_HAPS; g++) begin : g_utab
      localparam longint unsigned DIV = (g == 0) ? 1 : g;
      localparam logic [31:0] UVAL = 32'((64'h8000_0000 + DIV / 2) / DIV);
      assign u_tab[g] = UVAL;
   end
   localparam logic [31:0] U_RESET = 32'((64'h8000_0000 + MAX_HAPS / 2) / MAX_HAPS);

   back_state_type state_ff, state_in;
   item_type    item_ff, item_in;
   logic [31:0] u_ff;
   logic [31:0] prev_rd_ff;
   logic        prev_vld_rd_ff;
   logic [31:0] cur_rd_ff;
   logic [63:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [31:0] prior_ff, prior_in;
   logic [63:0] prod_ff, prod_in;
   logic [37:0] sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in, k_ff, k_in, n_eff;
   logic [37:0] rem_ff, rem_in;
   logic [32:0] numlo_ff, numlo_in, quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [31:0] f_ff, f_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  rsp_index_ff;
   logic [31:0] rsp_prob_ff;
   logic [37:0] rsp_sum_ff;
   logic        rsp_done_ff;
   logic        rsp_load;

   logic [31:0] prev_mem [MAX_HAPS];
   logic [31:0] cur_mem [MAX_HAPS];
   logic [MAX_HAPS-1:0] prev_vld_ff;
   logic        cur_we, prev_we;

   logic [31:0] prev_val, stay_prob, prior_sat, cur_val, quo_sat;
   logic [32:0] rnd1, rnd2, prior_sum;
   logic [38:0] sum_add, rem_shift;
   logic [37:0] sum_sat, rem_next;
   logic [63:0] num;
   logic        ge, last;

   always_comb begin
      if (hap_count == 7'd0) begin
         n_eff = CW'(1);
      end else if (hap_count > 7'(MAX_HAPS)) begin
         n_eff = CW'(MAX_HAPS);
      end else begin
         n_eff = CW'(hap_count);
      end
   end

   assign prev_val    = prev_vld_rd_ff ? prev_rd_ff : U_RESET;
   assign stay_prob   = ONE_Q31 - item_ff.recomb;
   assign rnd1        = 33'((p1_ff + HALF_Q31) >> 31);
   assign rnd2        = 33'((p2_ff + HALF_Q31) >> 31);
   assign prior_sum   = rnd1 + rnd2;
   assign prior_sat   = (prior_sum > 33'(ONE_Q31)) ? ONE_Q31 : prior_sum[31:0];
   assign cur_val     = 32'((prod_ff + HALF_Q31) >> 31);
   assign sum_add     = 39'(sum_ff) + 39'(cur_val);
   assign sum_sat     = (sum_add > 39'(SUM_CAP)) ? SUM_CAP : sum_add[37:0];
   assign num         = {1'b0, cur_rd_ff, 31'b0} + 64'(sum_ff >> 1);
   // Restoring division, one quotient bit per cycle.
   assign rem_shift   = {rem_ff, numlo_ff[32]};
   assign ge          = (rem_shift >= 39'(sum_ff));
   assign rem_next    = ge ? 38'(rem_shift - 39'(sum_ff)) : rem_shift[37:0];
   assign quo_sat     = (quo_ff > 33'(ONE_Q31)) ? ONE_Q31 : quo_ff[31:0];
   assign last        = ((k_ff + CW'(1)) == cnt_ff);
   assign rsp_load    = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);
   assign q_pop       = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      prior_in = prior_ff;
      prod_in  = prod_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      numlo_in = numlo_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      f_in     = f_ff;
      cur_we   = 1'b0;
      prev_we  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            p1_in    = 64'(prev_val) * 64'(stay_prob);
            p2_in    = 64'(item_ff.recomb) * 64'(u_ff);
            state_in = S_ADD;
         end
         S_ADD: begin
            prior_in = item_ff.first_site ? u_ff : prior_sat;
            state_in = S_EMUL;
         end
         S_EMUL: begin
            prod_in  = 64'(prior_ff) * 64'(item_ff.emit);
            state_in = S_ACC;
         end
         S_ACC: begin
            cur_we = 1'b1;
            sum_in = sum_sat;
            cnt_in = cnt_ff + CW'(1);
            if ((cnt_ff + CW'(1)) >= n_eff) begin
               k_in     = '0;
               state_in = S_NREAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_NREAD: begin
            state_in = S_NLOAD;
         end
         S_NLOAD: begin
            if (sum_ff == 38'd0) begin
               f_in     = u_ff;
               state_in = S_OUT;
            end else begin
               rem_in   = 38'(num[63:33]);
               numlo_in = num[32:0];
               quo_in   = '0;
               dcnt_in  = 6'(QUO_BITS);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (dcnt_ff != 6'd0) begin
               rem_in   = rem_next;
               numlo_in = {numlo_ff[31:0], 1'b0};
               quo_in   = {quo_ff[31:0], ge};
               dcnt_in  = dcnt_ff - 6'd1;
            end else begin
               f_in     = quo_sat;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               prev_we = 1'b1;
               if (last) begin
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = S_NREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         prev_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         if (prev_we) begin
            prev_vld_ff[k_ff[IW-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      u_ff           <= u_tab[n_eff];
      p1_ff          <= p1_in;
      p2_ff          <= p2_in;
      prior_ff       <= prior_in;
      prod_ff        <= prod_in;
      rem_ff         <= rem_in;
      numlo_ff       <= numlo_in;
      quo_ff         <= quo_in;
      dcnt_ff        <= dcnt_in;
      f_ff           <= f_in;
      prev_vld_rd_ff <= prev_vld_ff[cnt_ff[IW-1:0]];
      if (rsp_load) begin
         rsp_index_ff <= 6'(k_ff);
         rsp_prob_ff  <= f_ff;
         rsp_sum_ff   <= sum_ff;
         rsp_done_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[k_ff[IW-1:0]] <= f_ff;
      end
      prev_rd_ff <= prev_mem[cnt_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[cnt_ff[IW-1:0]] <= cur_val;
      end
      cur_rd_ff <= cur_mem[k_ff[IW-1:0]];
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hap_index    = rsp_index_ff;
   assign rsp.forward_prob = rsp_prob_ff;
   assign rsp.scale_sum    = rsp_sum_ff;
   assign rsp.site_done    = rsp_done_ff;

endmodule
`default_nettype wire

/* hw/rtl/haplotype_hmm_forward_scaled.sv */
// Each haplotype transaction passes through the back-end multiply sequencer (S_MUL, S_ADD,
// S_EMUL, S_ACC); a 2-entry queue lets the front accept while the back end works.
// At the end of a site every haplotype goes through a memory read, a 33-step
// bit-serial divider and an output load; the divider is skipped when the scale sum is zero.
// Reset is synchronous; the stored prior reads as the uniform value for MAX_HAPS
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module haplotype_hmm_forward_scaled import hhfs_pkg::*; #(
   parameter int MAX_HAPS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   hhfs_req_if.sink        req_chan,
   hhfs_rsp_if.source      rsp_chan,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [6:0] csr_data
);

   logic [6:0] hap_count_ff, hap_count_in;
   logic       q_push, q_full, q_pop, q_valid;
   item_type   push_item, q_item;

   assign csr_ready    = 1'b1;
   assign hap_count_in = (csr_valid && csr_ready) ? csr_data : hap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hap_count_ff <= 7'd64;
      end else begin
         hap_count_ff <= hap_count_in;
      end
   end

   hhfs_front u_front (
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (push_item)
   );

   hhfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (q_item)
   );

   hhfs_back #(.MAX_HAPS(MAX_HAPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .hap_count (hap_count_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.forward_prob <= ONE_Q31)
      else $error("forward value above one");
   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.scale_sum <= SUM_CAP)
      else $error("scale sum above saturation limit");
   a_zero_sum_uniform: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.scale_sum == 38'd0) |-> rsp_chan.forward_prob != 32'd0)
      else $error("zero scale sum did not give the uniform value");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none

class forward_scoreboard;
   localparam logic [63:0] ONE = 64'h8000_0000;
   localparam logic [63:0] CAP = 64'h20_0000_0000;
   int unsigned hap_count_reg;
   logic [63:0] prior_vec [64];
   logic [63:0] site_vec [64];
   logic [63:0] site_sum;
   int unsigned hap_pos;
   logic [5:0]  want_index [$];
   logic [31:0] want_prob [$];
   logic [37:0] want_sum [$];
   logic        want_done [$];
   int unsigned errors;

   function new();
      hap_count_reg = 64;
      for (int i = 0; i < 64; i++) prior_vec[i] = 64'd33554432;
      site_sum = 0;
      hap_pos = 0;
      errors = 0;
   endfunction

   function int unsigned live_count();
      if (hap_count_reg < 1) return 1;
      if (hap_count_reg > 64) return 64;
      return hap_count_reg;
   endfunction

   function logic [63:0] uniform_of(int unsigned n);
      return (ONE + n / 2) / n;
   endfunction

   function logic [63:0] clip(logic [63:0] v);
      return v > ONE ? ONE : v;
   endfunction

   function logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      return (a * b + 64'h4000_0000) >> 31;
   endfunction

   function int pending();
      return want_index.size();
   endfunction

   function void note_item(logic fs, logic ra, logic qa, logic qm,
                           logic [31:0] rp, logic [31:0] em, logic [31:0] ep);
      int unsigned n;
      logic [63:0] u, r, e, pr, f;
      n = live_count();
      u = uniform_of(n);
      r = clip(rp);
      e = (qm || ra == qa) ? clip(ep) : clip(em);
      if (fs) pr = u;
      else pr = clip(qmul(prior_vec[hap_pos], ONE - r) + qmul(r, u));
      site_vec[hap_pos] = qmul(pr, e);
      site_sum = site_sum + site_vec[hap_pos];
      if (site_sum > CAP) site_sum = CAP;
      hap_pos = hap_pos + 1;
      if (hap_pos < n) return;
      for (int k = 0; k < hap_pos; k++) begin
         if (site_sum == 0) f = u;
         else f = clip((site_vec[k] * ONE + site_sum / 2) / site_sum);
         prior_vec[k] = f;
         want_index.push_back(k[5:0]);
         want_prob.push_back(f[31:0]);
         want_sum.push_back(site_sum[37:0]);
         want_done.push_back(k + 1 == hap_pos);
      end
      site_sum = 0;
      hap_pos = 0;
   endfunction

   task report(string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   task check_result(logic [5:0] idx, logic [31:0] fp, logic [37:0] ss, logic sd);
      if (want_index.size() == 0) begin
         report($sformatf("unexpected result idx=%0d", idx));
         return;
      end
      if (idx !== want_index[0])
         report($sformatf("hap_index %0d, wanted %0d", idx, want_index[0]));
      if (fp !== want_prob[0])
         report($sformatf("forward_prob %h, wanted %h (idx %0d)", fp, want_prob[0], idx));
      if (ss !== want_sum[0])
         report($sformatf("scale_sum %h, wanted %h (idx %0d)", ss, want_sum[0], idx));
      if (sd !== want_done[0])
         report($sformatf("site_done %b, wanted %b (idx %0d)", sd, want_done[0], idx));
      void'(want_index.pop_front());
      void'(want_prob.pop_front());
      void'(want_sum.pop_front());
      void'(want_done.pop_front());
   endtask
endclass

module testbench;
   import hhfs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [6:0] csr_data = 0;
   bit calm = 0;
   bit hold_rsp = 0;
   int hold_cycles = 0;

   hhfs_req_if req_chan ();
   hhfs_rsp_if rsp_chan ();

   haplotype_hmm_forward_scaled uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   forward_scoreboard board = new();

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req_chan.valid = 0;
      req_chan.first_site = 0;
      req_chan.ref_allele = 0;
      req_chan.query_allele = 0;
      req_chan.query_missing = 0;
      req_chan.recomb_prob = 0;
      req_chan.emit_mismatch = 0;
      req_chan.emit_match = 0;
      rsp_chan.ready = 0;
   end

   // Receiver: random stall bursts, plus a forced long hold when requested.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_result(rsp_chan.hap_index, rsp_chan.forward_prob,
                               rsp_chan.scale_sum, rsp_chan.site_done);
         if (hold_rsp) begin
            rsp_chan.ready <= 0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_cycles <= $urandom_range(1, 12);
            rsp_chan.ready <= 0;
         end else begin
            rsp_chan.ready <= 1;
         end
      end
   end

   function logic [31:0] pick_prob();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h8000_0000;
         2: return $urandom();
         3: return $urandom_range(32'h7FFF_FFFF, 32'h0);
         default: return $urandom_range(32'h8000_0000, 32'h0);
      endcase
   endfunction

   task automatic send_item(logic fs, logic ra, logic qa, logic qm,
                            logic [31:0] rp, logic [31:0] em, logic [31:0] ep);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 12);
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.first_site <= fs;
      req_chan.ref_allele <= ra;
      req_chan.query_allele <= qa;
      req_chan.query_missing <= qm;
      req_chan.recomb_prob <= rp;
      req_chan.emit_mismatch <= em;
      req_chan.emit_match <= ep;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(fs, ra, qa, qm, rp, em, ep);
   endtask

   task automatic send_random(logic fs);
      send_item(fs, 1'($urandom()), 1'($urandom()), $urandom_range(0, 3) == 0,
                pick_prob(), pick_prob(), pick_prob());
   endtask

   task automatic wait_drained();
      req_chan.valid <= 0;
      while (board.pending() != 0) @(posedge clock);
      // Extra idle margin after the last result has come back.
      repeat (50) @(posedge clock);
   endtask

   task automatic write_count(logic [6:0] v);
      wait_drained();
      csr_valid <= 1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      board.hap_count_reg = v;
      csr_valid <= 0;
   endtask

   task automatic run_sites(int sites);
      int n;
      n = board.live_count();
      for (int s = 0; s < sites; s++)
         for (int h = 0; h < n; h++)
            send_random(($urandom_range(0, 19) == 0) ? ~(h == 0) : (s == 0));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: first site never flagged with the reset prior, count 2.
      write_count(7'd2);
      send_item(0, 0, 0, 0, 32'h0, 32'h0, 32'h8000_0000);
      send_item(0, 1, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      // Zero scale sum.
      send_item(1, 0, 1, 0, 32'h1234, 32'h0, 32'hFFFF_FFFF);
      send_item(1, 1, 1, 0, 32'h0, 32'hFFFF_FFFF, 32'h0);
      // Missing query counts as a match; mixed flags.
      send_item(1, 1, 0, 1, 32'h8000_0000, 32'h0, 32'h8000_0000);
      send_item(0, 0, 1, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      // Count zero acts as one.
      write_count(7'd0);
      send_item(1, 0, 0, 0, 32'h0, 32'h0, 32'h8000_0000);
      send_item(0, 1, 1, 0, 32'h4000_0000, 32'h0, 32'h4000_0000);
      // Count above the maximum acts as the maximum.
      write_count(7'd127);
      send_item(1, 1, 0, 0, 32'h0, 32'h8000_0000, 32'h0);
      for (int h = 1; h < 64; h++) send_random(1);
      // Count changed mid-site: shrink below items already counted.
      write_count(7'd5);
      for (int h = 0; h < 3; h++) send_random(1);
      write_count(7'd2);
      send_random(0);
      write_count(7'd1);

      run_sites(20);
      write_count(7'd3);
      run_sites(15);

      // Long receiver hold while the sender keeps offering.
      write_count(7'd4);
      hold_rsp = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end
         run_sites(6);
      join
      // Sender pauses until everything has come back.
      req_chan.valid <= 0;
      while (board.pending() != 0) @(posedge clock);
      write_count(7'd7);
      run_sites(22);
      write_count(7'd64);
      run_sites(1);
      calm = 1;
      write_count(7'd6);
      run_sites(8);
      wait_drained();
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(20 * 2000000);
      $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire
